FILE: src/cau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg - shared types and helpers for the complex arithmetic unit
// Fixed-point format, operation codes, pipeline word layout and saturation.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS = 16;
  // quotient bits kept by the divider: anything at or above 2^34 saturates
  localparam int QW = 34;
  localparam int RT_STEPS = 32;
  // low magnitude bits shifted into the divider after the initial remainder
  localparam int LOW_W = 33 - FRAC_BITS;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_MOD  = 3'd5,
    OP_EQ   = 3'd6
  } op_t;

  typedef struct packed {
    logic        ov;
    logic [31:0] val;
  } sat_t;

  typedef struct packed {
    logic        valid;
    op_t         kind;
    logic [31:0] rr;
    logic [31:0] ri;
    logic        ov;
    logic        dz;
    logic        eq;
  } side_t;

  typedef struct packed {
    side_t          side;
    logic           neg_r;
    logic           neg_i;
    logic           huge_r;
    logic           huge_i;
    logic [63:0]    den;
    logic [63:0]    rem_r;
    logic [63:0]    rem_i;
    logic [QW-1:0]  low_r;
    logic [QW-1:0]  low_i;
    logic [QW-1:0]  q_r;
    logic [QW-1:0]  q_i;
    logic [33:0]    srem;
    logic [31:0]    sroot;
    logic [63:0]    sbits;
  } lane_t;

  // clamp sign and magnitude to 32-bit two's complement
  function automatic sat_t sat_sm(input logic neg, input logic [64:0] mag);
    sat_t s;
    s.ov  = 1'b0;
    s.val = mag[31:0];
    if (neg) begin
      if (mag > 65'h0_8000_0000) begin
        s.ov  = 1'b1;
        s.val = 32'h8000_0000;
      end else begin
        s.val = ~mag[31:0] + 32'd1;
      end
    end else if (mag > 65'h0_7FFF_FFFF) begin
      s.ov  = 1'b1;
      s.val = 32'h7FFF_FFFF;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: src/cau_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front - operand stages of the complex arithmetic unit
// Simple ops, shared multipliers, sums, magnitudes and divider set-up.
// ----------------------------------------------------------------------------
module cau_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_vld,
  input  wire logic [2:0]         in_kind,
  input  wire logic signed [31:0] in_a_real,
  input  wire logic signed [31:0] in_a_imag,
  input  wire logic signed [31:0] in_b_real,
  input  wire logic signed [31:0] in_b_imag,
  input  wire logic [30:0]        in_tolerance,
  output cau_pkg::lane_t          lane_o
);

  function automatic cau_pkg::sat_t sat33(input logic signed [32:0] x);
    logic [32:0] m;
    m = x[32] ? 33'(-x) : 33'(x);
    return cau_pkg::sat_sm(x[32], {32'd0, m});
  endfunction

  // valid bits drop while reset is held
  function automatic cau_pkg::side_t vld_gate(input cau_pkg::side_t s, input logic en);
    cau_pkg::side_t g;
    g       = s;
    g.valid = s.valid & en;
    return g;
  endfunction

  // stage 1: registered inputs
  cau_pkg::side_t     s1_r;
  logic signed [31:0] ar1_r, ai1_r, br1_r, bi1_r;
  logic [30:0]        tol1_r;

  always_ff @(posedge clk) begin
    s1_r.valid <= in_vld & rst_n;
    s1_r.kind  <= cau_pkg::op_t'(in_kind);
    s1_r.rr    <= '0;
    s1_r.ri    <= '0;
    s1_r.ov    <= 1'b0;
    s1_r.dz    <= 1'b0;
    s1_r.eq    <= 1'b0;
    ar1_r      <= in_a_real;
    ai1_r      <= in_a_imag;
    br1_r      <= in_b_real;
    bi1_r      <= in_b_imag;
    tol1_r     <= in_tolerance;
  end

  logic signed [32:0] dr1, di1;
  logic [32:0]        mr1, mi1;
  cau_pkg::sat_t      sa, sb;
  cau_pkg::side_t     s2_nxt;
  logic signed [31:0] x5_nxt, x6_nxt;

  always_comb begin
    dr1 = 33'(ar1_r) - 33'(br1_r);
    di1 = 33'(ai1_r) - 33'(bi1_r);
    mr1 = dr1[32] ? 33'(-dr1) : 33'(dr1);
    mi1 = di1[32] ? 33'(-di1) : 33'(di1);
    sa  = '0;
    sb  = '0;
    s2_nxt    = s1_r;
    s2_nxt.dz = (br1_r == 32'sd0) && (bi1_r == 32'sd0);
    s2_nxt.eq = (mr1 < {2'b00, tol1_r}) && (mi1 < {2'b00, tol1_r});
    x5_nxt    = br1_r;
    x6_nxt    = bi1_r;
    case (s1_r.kind)
      cau_pkg::OP_ADD: begin
        sa = sat33(33'(ar1_r) + 33'(br1_r));
        sb = sat33(33'(ai1_r) + 33'(bi1_r));
      end
      cau_pkg::OP_SUB: begin
        sa = sat33(dr1);
        sb = sat33(di1);
      end
      cau_pkg::OP_CONJ: begin
        sa.val = ar1_r;
        sb     = sat33(-33'(ai1_r));
      end
      cau_pkg::OP_MOD: begin
        x5_nxt = ar1_r;
        x6_nxt = ai1_r;
      end
      cau_pkg::OP_EQ: begin
        // only meaningful when both magnitudes are below tolerance
        x5_nxt = {1'b0, mr1[30:0]};
        x6_nxt = {1'b0, mi1[30:0]};
      end
      default: begin
      end
    endcase
    s2_nxt.rr = sa.val;
    s2_nxt.ri = sb.val;
    s2_nxt.ov = sa.ov | sb.ov;
  end

  // stage 2: multiplier operands
  cau_pkg::side_t     s2_r;
  logic signed [31:0] ar2_r, ai2_r, br2_r, bi2_r, x5_r, x6_r;
  logic [30:0]        tol2_r;

  always_ff @(posedge clk) begin
    s2_r   <= vld_gate(s2_nxt, rst_n);
    ar2_r  <= ar1_r;
    ai2_r  <= ai1_r;
    br2_r  <= br1_r;
    bi2_r  <= bi1_r;
    x5_r   <= x5_nxt;
    x6_r   <= x6_nxt;
    tol2_r <= tol1_r;
  end

  // stage 3: products
  cau_pkg::side_t     s3_r;
  logic signed [63:0] prr_r, pii_r, pri_r, pir_r, p5_r, p6_r;
  logic [61:0]        tsq_r;

  always_ff @(posedge clk) begin
    s3_r  <= vld_gate(s2_r, rst_n);
    prr_r <= ar2_r * br2_r;
    pii_r <= ai2_r * bi2_r;
    pri_r <= ar2_r * bi2_r;
    pir_r <= ai2_r * br2_r;
    p5_r  <= x5_r * x5_r;
    p6_r  <= x6_r * x6_r;
    tsq_r <= tol2_r * tol2_r;
  end

  logic signed [64:0] pr_nxt, pi_nxt;
  logic [63:0]        ss_nxt;
  cau_pkg::side_t     s4_nxt;

  always_comb begin
    ss_nxt = {1'b0, p5_r[62:0]} + {1'b0, p6_r[62:0]};
    s4_nxt = s3_r;
    s4_nxt.eq = s3_r.eq && (ss_nxt < {2'b00, tsq_r});
    if (s3_r.kind == cau_pkg::OP_MUL) begin
      pr_nxt = 65'(prr_r) - 65'(pii_r);
      pi_nxt = 65'(pri_r) + 65'(pir_r);
    end else begin
      pr_nxt = 65'(prr_r) + 65'(pii_r);
      pi_nxt = 65'(pir_r) - 65'(pri_r);
    end
  end

  // stage 4: exact parts
  cau_pkg::side_t     s4_r;
  logic signed [64:0] pr4_r, pi4_r;
  logic [63:0]        ss4_r;

  always_ff @(posedge clk) begin
    s4_r  <= vld_gate(s4_nxt, rst_n);
    pr4_r <= pr_nxt;
    pi4_r <= pi_nxt;
    ss4_r <= ss_nxt;
  end

  // stage 5: sign and magnitude
  cau_pkg::side_t s5_r;
  logic           ng_r5_r, ng_i5_r;
  logic [63:0]    mg_r5_r, mg_i5_r, ss5_r;

  always_ff @(posedge clk) begin
    s5_r    <= vld_gate(s4_r, rst_n);
    ng_r5_r <= pr4_r[64];
    ng_i5_r <= pi4_r[64];
    mg_r5_r <= pr4_r[64] ? 64'(-pr4_r) : pr4_r[63:0];
    mg_i5_r <= pi4_r[64] ? 64'(-pi4_r) : pi4_r[63:0];
    ss5_r   <= ss4_r;
  end

  logic [64:0]   rnd_r, rnd_i;
  cau_pkg::sat_t mu_r, mu_i;

  always_comb begin
    rnd_r = ({1'b0, mg_r5_r} + (65'd1 << (cau_pkg::FRAC_BITS - 1))) >> cau_pkg::FRAC_BITS;
    rnd_i = ({1'b0, mg_i5_r} + (65'd1 << (cau_pkg::FRAC_BITS - 1))) >> cau_pkg::FRAC_BITS;
    mu_r  = cau_pkg::sat_sm(ng_r5_r, rnd_r);
    mu_i  = cau_pkg::sat_sm(ng_i5_r, rnd_i);
    lane_o      = '0;
    lane_o.side = s5_r;
    unique case (s5_r.kind)
      cau_pkg::OP_MUL: begin
        lane_o.side.rr = mu_r.val;
        lane_o.side.ri = mu_i.val;
        lane_o.side.ov = mu_r.ov | mu_i.ov;
      end
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_CONJ: begin
      end
      default: begin
        lane_o.side.rr = '0;
        lane_o.side.ri = '0;
        lane_o.side.ov = 1'b0;
      end
    endcase
    if (s5_r.kind != cau_pkg::OP_EQ) lane_o.side.eq = 1'b0;
    if (s5_r.kind != cau_pkg::OP_DIV) lane_o.side.dz = 1'b0;
    lane_o.neg_r  = ng_r5_r;
    lane_o.neg_i  = ng_i5_r;
    lane_o.den    = ss5_r;
    lane_o.huge_r = (mg_r5_r >> cau_pkg::LOW_W) >= ss5_r;
    lane_o.huge_i = (mg_i5_r >> cau_pkg::LOW_W) >= ss5_r;
    lane_o.rem_r  = mg_r5_r >> cau_pkg::LOW_W;
    lane_o.rem_i  = mg_i5_r >> cau_pkg::LOW_W;
    lane_o.low_r  = {mg_r5_r[cau_pkg::LOW_W-1:0], {(cau_pkg::FRAC_BITS + 1){1'b0}}};
    lane_o.low_i  = {mg_i5_r[cau_pkg::LOW_W-1:0], {(cau_pkg::FRAC_BITS + 1){1'b0}}};
    lane_o.sbits  = ss5_r;
  end

endmodule
`default_nettype wire

FILE: src/cau_iter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_iter - pipelined divider pair and integer square root
// One restoring quotient bit per part per stage, and one root bit per stage up to RT_STEPS.
// ----------------------------------------------------------------------------
module cau_iter (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cau_pkg::lane_t lane_i,
  output cau_pkg::lane_t      lane_o
);

  function automatic cau_pkg::lane_t step(input cau_pkg::lane_t x, input logic do_rt);
    cau_pkg::lane_t y;
    logic [64:0]    tr, ti;
    logic [35:0]    sr, st;
    y  = x;
    tr = {x.rem_r, x.low_r[cau_pkg::QW-1]};
    ti = {x.rem_i, x.low_i[cau_pkg::QW-1]};
    y.low_r = x.low_r << 1;
    y.low_i = x.low_i << 1;
    if (tr >= {1'b0, x.den}) begin
      y.rem_r = 64'(tr - {1'b0, x.den});
      y.q_r   = {x.q_r[cau_pkg::QW-2:0], 1'b1};
    end else begin
      y.rem_r = tr[63:0];
      y.q_r   = {x.q_r[cau_pkg::QW-2:0], 1'b0};
    end
    if (ti >= {1'b0, x.den}) begin
      y.rem_i = 64'(ti - {1'b0, x.den});
      y.q_i   = {x.q_i[cau_pkg::QW-2:0], 1'b1};
    end else begin
      y.rem_i = ti[63:0];
      y.q_i   = {x.q_i[cau_pkg::QW-2:0], 1'b0};
    end
    // root digit: bring down two bits, try 4*root+1
    sr = {x.srem, x.sbits[63:62]};
    st = {2'b00, x.sroot, 2'b01};
    if (do_rt) begin
      y.sbits = x.sbits << 2;
      if (sr >= st) begin
        y.srem  = 34'(sr - st);
        y.sroot = {x.sroot[30:0], 1'b1};
      end else begin
        y.srem  = sr[33:0];
        y.sroot = {x.sroot[30:0], 1'b0};
      end
    end
    return y;
  endfunction

  for (genvar k = 0; k < cau_pkg::QW; k++) begin : g_stg
    cau_pkg::lane_t src, stg_nxt, stg_r;
    if (k == 0) begin : g_first
      assign src = lane_i;
    end else begin : g_next
      assign src = g_stg[k-1].stg_r;
    end
    always_comb begin
      stg_nxt            = step(src, k < cau_pkg::RT_STEPS);
      stg_nxt.side.valid = src.side.valid & rst_n;
    end
    always_ff @(posedge clk) begin
      stg_r <= stg_nxt;
    end
  end

  assign lane_o = g_stg[cau_pkg::QW-1].stg_r;

endmodule
`default_nettype wire

FILE: src/complex_arith_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arith_unit - pipelined complex-number arithmetic unit
// Add, subtract, multiply, divide, conjugate, modulus and approximate
// equality on signed Q16.16 complex operands.
// ----------------------------------------------------------------------------
// usage:
//   a word is taken at a rising edge with start high and busy low; busy is
//   always low, so a new word can be given every cycle
//   one result word per input word, in input order, shown for exactly one
//   cycle with out_valid high
//   the path runs through five operand stages (inputs, multiplier operands,
//   products, sums, magnitudes), 34 divider/root stages and one output register
//   throughput is one word per cycle; the 34-stage quotient pipeline sets the
//   latency, every op goes through it so results stay in order
//   divide by zero gives zero parts with out_div_zero; saturated parts raise
//   out_overflow; out_is_equal flags the equality test
//   synchronous reset clears all valid bits, so no result appears until new
//   words arrive; the receiver cannot hold results off
// ----------------------------------------------------------------------------
module complex_arith_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_kind,
  input  wire logic signed [31:0] in_a_real,
  input  wire logic signed [31:0] in_a_imag,
  input  wire logic signed [31:0] in_b_real,
  input  wire logic signed [31:0] in_b_imag,
  input  wire logic [30:0]        in_tolerance,
  output logic                    out_valid,
  output logic signed [31:0]      out_res_real,
  output logic signed [31:0]      out_res_imag,
  output logic                    out_div_zero,
  output logic                    out_overflow,
  output logic                    out_is_equal
);

  function automatic cau_pkg::sat_t div_part(input logic neg, input logic huge,
                                             input logic [cau_pkg::QW-1:0] q);
    logic [cau_pkg::QW:0] q1;
    logic [64:0]          mag;
    q1  = {1'b0, q} + 1'b1;
    mag = huge ? 65'h1_0000_0000 : 65'(q1[cau_pkg::QW:1]);
    return cau_pkg::sat_sm(neg, mag);
  endfunction

  cau_pkg::lane_t front_lane, back_lane;

  assign busy = 1'b0;

  cau_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (start),
    .in_kind      (in_kind),
    .in_a_real    (in_a_real),
    .in_a_imag    (in_a_imag),
    .in_b_real    (in_b_real),
    .in_b_imag    (in_b_imag),
    .in_tolerance (in_tolerance),
    .lane_o       (front_lane)
  );

  cau_iter u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .lane_i (front_lane),
    .lane_o (back_lane)
  );

  cau_pkg::sat_t  qr, qi, rt;
  logic [31:0]    rr_nxt, ri_nxt;
  logic           ov_nxt;

  always_comb begin
    qr     = div_part(back_lane.neg_r, back_lane.huge_r, back_lane.q_r);
    qi     = div_part(back_lane.neg_i, back_lane.huge_i, back_lane.q_i);
    rt     = cau_pkg::sat_sm(1'b0, {33'd0, back_lane.sroot});
    rr_nxt = back_lane.side.rr;
    ri_nxt = back_lane.side.ri;
    ov_nxt = back_lane.side.ov;
    case (back_lane.side.kind)
      cau_pkg::OP_DIV: begin
        if (back_lane.side.dz) begin
          rr_nxt = '0;
          ri_nxt = '0;
          ov_nxt = 1'b0;
        end else begin
          rr_nxt = qr.val;
          ri_nxt = qi.val;
          ov_nxt = qr.ov | qi.ov;
        end
      end
      cau_pkg::OP_MOD: begin
        rr_nxt = rt.val;
        ri_nxt = '0;
        ov_nxt = rt.ov;
      end
      default: begin
      end
    endcase
  end

  logic        valid_r;
  logic [31:0] rr_r, ri_r;
  logic        dz_r, ov_r, eq_r;

  always_ff @(posedge clk) begin
    valid_r <= back_lane.side.valid & rst_n;
    rr_r    <= rr_nxt;
    ri_r    <= ri_nxt;
    dz_r    <= back_lane.side.dz;
    ov_r    <= ov_nxt;
    eq_r    <= back_lane.side.eq;
  end

  assign out_valid    = valid_r;
  assign out_res_real = rr_r;
  assign out_res_imag = ri_r;
  assign out_div_zero = dz_r;
  assign out_overflow = ov_r;
  assign out_is_equal = eq_r;

endmodule
`default_nettype wire
